// ===== sv/lfu_kvc_pkg.sv =====
package lfu_kvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_CFG_W = 5;

  localparam logic [CAP_CFG_W-1:0] CAP_RESET = 5'd16;
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } rsp_t;

  typedef logic [CAP_CFG_W-1:0] cfg_t;

endpackage

// ===== sv/lfu_kvc_stream_if.sv =====
interface lfu_kvc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== sv/lfu_key_value_cache_unit.sv =====
// LFU key-value cache. Each request (get or set) is answered by exactly one
// response. A request holds the block from its acceptance until its update:
// one pass over the entry RAM, one entry per cycle through its single read
// port, finds the key, the first free slot and the replacement victim, then
// the update state applies the update. The update stalls while an earlier
// response is still waiting in the output register; otherwise the next
// request is taken while the response waits. Writing the capacity register
// clears the cache at once; capacity above CAPACITY acts as CAPACITY, zero
// stores nothing.
module lfu_key_value_cache_unit #(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  lfu_kvc_stream_if.sink   req_chan,
  lfu_kvc_stream_if.source rsp_chan,
  lfu_kvc_stream_if.sink   cfg_chan
);
  import lfu_kvc_pkg::*;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CAP_LIM = (CAPACITY > 31) ? 31 : CAPACITY;
  localparam int ENT_W   = KEY_W + VAL_W + COUNT_BITS + STAMP_BITS;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  state_e state_q, state_d;

  cfg_t                  cap_q, cap_eff;
  logic [CAP_CFG_W-1:0]  occ_q, occ_d;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d;
  logic [CAPACITY-1:0]   valid_q, valid_d;

  req_t req_q;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q;

  logic                  hit_found_q, hit_found_d;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  entry_t                hit_ent_q, hit_ent_d;
  logic                  vic_found_q, vic_found_d;
  logic [IDX_W-1:0]      vic_idx_q, vic_idx_d;
  logic [KEY_W-1:0]      vic_key_q, vic_key_d;
  logic [COUNT_BITS-1:0] vic_count_q, vic_count_d;
  logic [STAMP_BITS-1:0] vic_age_q, vic_age_d;
  logic                  free_found_q, free_found_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;

  logic             out_vld_q, out_vld_d;
  rsp_t             out_rsp_q, out_rsp_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  entry_t           rd_ent;
  logic [STAMP_BITS-1:0] rd_age;

  logic in_accept, out_free, start, scanning, update_en, cfg_wr;

  assign cap_eff = (cap_q > CAP_CFG_W'(CAP_LIM)) ? CAP_CFG_W'(CAP_LIM) : cap_q;
  assign rd_ent  = entry_t'(ram_rdata);
  assign rd_age  = stamp_q - rd_ent.stamp;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid;
  assign in_accept      = req_chan.valid && req_chan.ready;
  assign out_free       = !out_vld_q || rsp_chan.ready;

  assign rsp_chan.valid   = out_vld_q;
  assign rsp_chan.payload = out_rsp_q;

  lfu_kvc_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == IDX_W'(CAPACITY - 1)) state_d = ST_LAST;
      ST_LAST:   state_d = ST_UPDATE;
      ST_UPDATE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_chan.ready = 1'b0;
    scanning       = 1'b0;
    update_en      = 1'b0;
    unique case (state_q)
      ST_IDLE:   req_chan.ready = 1'b1;
      ST_SCAN:   scanning = 1'b1;
      ST_LAST:   ;
      ST_UPDATE: update_en = out_free;
      default:   ;
    endcase
  end

  assign start = in_accept;

  // scan: key match, first free slot, victim (min count, then oldest)
  always_comb begin
    idx_d        = scanning ? idx_q + IDX_W'(1) : '0;
    cmp_vld_d    = scanning;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    hit_ent_d    = hit_ent_q;
    vic_found_d  = vic_found_q;
    vic_idx_d    = vic_idx_q;
    vic_key_d    = vic_key_q;
    vic_count_d  = vic_count_q;
    vic_age_d    = vic_age_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    if (start) begin
      hit_found_d  = 1'b0;
      vic_found_d  = 1'b0;
      free_found_d = 1'b0;
    end else if (cmp_vld_q) begin
      if (valid_q[cmp_idx_q]) begin
        if (!hit_found_q && rd_ent.key == req_q.lookup_key) begin
          hit_found_d = 1'b1;
          hit_idx_d   = cmp_idx_q;
          hit_ent_d   = rd_ent;
        end
        if (!vic_found_q || rd_ent.count < vic_count_q ||
            (rd_ent.count == vic_count_q && rd_age > vic_age_q)) begin
          vic_found_d = 1'b1;
          vic_idx_d   = cmp_idx_q;
          vic_key_d   = rd_ent.key;
          vic_count_d = rd_ent.count;
          vic_age_d   = rd_age;
        end
      end else if (!free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = cmp_idx_q;
      end
    end
  end

  // update and response
  always_comb begin
    logic             cap_zero, bump, full, do_ins;
    logic [IDX_W-1:0] ins_idx;
    cap_zero  = (cap_eff == '0);
    bump      = !(&hit_ent_q.count);
    full      = (occ_q >= cap_eff);
    do_ins    = full ? vic_found_q : free_found_q;
    ins_idx   = (full && !(free_found_q && free_idx_q < vic_idx_q)) ? vic_idx_q : free_idx_q;
    valid_d   = valid_q;
    occ_d     = occ_q;
    stamp_d   = stamp_q;
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = hit_ent_q;
    out_vld_d = out_vld_q && !rsp_chan.ready;
    out_rsp_d = out_rsp_q;
    if (update_en) begin
      out_vld_d             = 1'b1;
      out_rsp_d.hit         = 1'b0;
      out_rsp_d.read_value  = (req_q.opcode == OP_GET) ? MISS_VALUE : '0;
      out_rsp_d.evicted     = 1'b0;
      out_rsp_d.evicted_key = '0;
      if (!cap_zero) begin
        if (hit_found_q) begin
          out_rsp_d.hit = 1'b1;
          ram_we        = 1'b1;
          if (req_q.opcode == OP_GET) begin
            out_rsp_d.read_value = hit_ent_q.value;
          end else begin
            ram_wdata.value = req_q.write_value;
          end
          if (bump) begin
            ram_wdata.count = hit_ent_q.count + COUNT_BITS'(1);
            ram_wdata.stamp = stamp_q;
            stamp_d         = stamp_q + STAMP_BITS'(1);
          end
        end else if (req_q.opcode == OP_SET && do_ins) begin
          if (full) begin
            out_rsp_d.evicted     = 1'b1;
            out_rsp_d.evicted_key = vic_key_q;
            valid_d[vic_idx_q]    = 1'b0;
          end else begin
            occ_d = occ_q + CAP_CFG_W'(1);
          end
          valid_d[ins_idx] = 1'b1;
          ram_we           = 1'b1;
          ram_waddr        = ins_idx;
          ram_wdata.key    = req_q.lookup_key;
          ram_wdata.value  = req_q.write_value;
          ram_wdata.count  = COUNT_BITS'(1);
          ram_wdata.stamp  = stamp_q;
          stamp_d          = stamp_q + STAMP_BITS'(1);
        end
      end
    end
    if (cfg_wr) begin
      valid_d = '0;
      occ_d   = '0;
      stamp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cap_q        <= CAP_RESET;
      occ_q        <= '0;
      stamp_q      <= '0;
      valid_q      <= '0;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      hit_found_q  <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_wr) begin
        cap_q <= cfg_chan.payload;
      end
      occ_q        <= occ_d;
      stamp_q      <= stamp_d;
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      cmp_vld_q    <= cmp_vld_d;
      hit_found_q  <= hit_found_d;
      vic_found_q  <= vic_found_d;
      free_found_q <= free_found_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= req_chan.payload;
    end
    cmp_idx_q   <= idx_q;
    hit_idx_q   <= hit_idx_d;
    hit_ent_q   <= hit_ent_d;
    vic_idx_q   <= vic_idx_d;
    vic_key_q   <= vic_key_d;
    vic_count_q <= vic_count_d;
    vic_age_q   <= vic_age_d;
    free_idx_q  <= free_idx_d;
    out_rsp_q   <= out_rsp_d;
  end

`ifndef ASSERT_OFF
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(occ_q))
    else $error("occupancy out of step with valid bits");

  a_occ_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cap_eff)
    else $error("occupancy above capacity");

  a_rsp_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_UPDATE)
    else $error("response raised outside update");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_rsp_q.evicted |-> !out_rsp_q.hit)
    else $error("eviction reported on a hit");
`endif

endmodule

// ===== sv/lfu_kvc_ram.sv =====
module lfu_kvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
